/* hdl/hpmc_pkg.sv */
// ----------------------------------------------------------------------------
// hpmc_pkg
// Shared types and constants for the half-pel motion compensation block.
// ----------------------------------------------------------------------------
package hpmc_pkg;

  // Pixel and bus geometry
  localparam int PIX_W         = 8;
  localparam int HALF_BYTES    = 8;
  localparam int HALF_W        = PIX_W * HALF_BYTES;
  localparam int NARROW_WIDTH  = 8;
  localparam int MAX_WIDTH_DEF = 16;

  // Per-row interpolation controls handed to every lane
  typedef struct packed {
    logic half_x;
    logic half_y;
    logic average_mode;
  } mode_t;

endpackage

/* hdl/hpmc_if.sv */
// ----------------------------------------------------------------------------
// hpmc_if
// Valid/ready channels: reference row in, prediction row out.
// ----------------------------------------------------------------------------
interface hpmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [hpmc_pkg::HALF_W-1:0] ref_pixels_low;
  logic [hpmc_pkg::HALF_W-1:0] ref_pixels_high;
  logic [hpmc_pkg::PIX_W-1:0]  ref_pixel_extra;
  logic [hpmc_pkg::HALF_W-1:0] dest_pixels_low;
  logic [hpmc_pkg::HALF_W-1:0] dest_pixels_high;
  logic                        half_x;
  logic                        half_y;
  logic                        average_mode;
  logic                        wide_block;
  logic                        block_start;

  modport source (
    output valid, ref_pixels_low, ref_pixels_high, ref_pixel_extra,
           dest_pixels_low, dest_pixels_high, half_x, half_y,
           average_mode, wide_block, block_start,
    input  ready
  );
  modport sink (
    input  valid, ref_pixels_low, ref_pixels_high, ref_pixel_extra,
           dest_pixels_low, dest_pixels_high, half_x, half_y,
           average_mode, wide_block, block_start,
    output ready
  );
endinterface

interface hpmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [hpmc_pkg::HALF_W-1:0] pred_pixels_low;
  logic [hpmc_pkg::HALF_W-1:0] pred_pixels_high;

  modport source (output valid, pred_pixels_low, pred_pixels_high, input ready);
  modport sink   (input valid, pred_pixels_low, pred_pixels_high, output ready);
endinterface

/* hdl/hpmc_lane.sv */
// ----------------------------------------------------------------------------
// hpmc_lane
// One pixel of the prediction: half-pel interpolation plus optional average.
// ----------------------------------------------------------------------------
module hpmc_lane (
  input  logic [hpmc_pkg::PIX_W-1:0] a,      // current row, this pixel
  input  logic [hpmc_pkg::PIX_W-1:0] b,      // current row, right neighbor
  input  logic [hpmc_pkg::PIX_W-1:0] c,      // previous row, this pixel
  input  logic [hpmc_pkg::PIX_W-1:0] d,      // previous row, right neighbor
  input  logic [hpmc_pkg::PIX_W-1:0] dest,
  input  hpmc_pkg::mode_t            mode,
  input  logic                       en,
  output logic [hpmc_pkg::PIX_W-1:0] pix
);

  localparam int PW = hpmc_pkg::PIX_W;

  logic [PW+1:0] sum4;
  logic [PW:0]   sum_h;
  logic [PW:0]   sum_v;
  logic [PW-1:0] pred;
  logic [PW:0]   sum_avg;

  // Candidate interpolations
  assign sum4  = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d} + (PW+2)'(2);
  assign sum_h = {1'b0, a} + {1'b0, b} + (PW+1)'(1);
  assign sum_v = {1'b0, a} + {1'b0, c} + (PW+1)'(1);

  // Mode select
  always_comb begin
    if (mode.half_x && mode.half_y) begin
      pred = sum4[PW+1:2];
    end else if (mode.half_x) begin
      pred = sum_h[PW:1];
    end else if (mode.half_y) begin
      pred = sum_v[PW:1];
    end else begin
      pred = a;
    end
  end

  // Rounded merge with the destination pixel
  assign sum_avg = {1'b0, pred} + {1'b0, dest} + (PW+1)'(1);

  always_comb begin
    if (!en) begin
      pix = '0;
    end else if (mode.average_mode) begin
      pix = sum_avg[PW:1];
    end else begin
      pix = pred;
    end
  end

endmodule

/* hdl/hpmc_merge.sv */
// ----------------------------------------------------------------------------
// hpmc_merge
// Packs lane pixels into the result words and holds them in a two-entry
// output buffer so the input side keeps moving while a result waits.
// ----------------------------------------------------------------------------
module hpmc_merge #(
  parameter int MAX_WIDTH = hpmc_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hpmc_pkg::PIX_W-1:0] lane_pix [MAX_WIDTH],
  input  logic                       push,
  output logic                       space,
  hpmc_out_if.source                 pred_row
);

  localparam int PW = hpmc_pkg::PIX_W;
  localparam int HB = hpmc_pkg::HALF_BYTES;
  localparam int HW = hpmc_pkg::HALF_W;

  logic [HW-1:0] new_low;
  logic [HW-1:0] new_high;
  logic [HW-1:0] slot0_low;
  logic [HW-1:0] slot0_high;
  logic [HW-1:0] slot1_low;
  logic [HW-1:0] slot1_high;
  logic [1:0]    count;
  logic          pop;

  // Pack lanes; bytes past the lane count are zero
  for (genvar i = 0; i < HB; i++) begin : g_pack
    if (i < MAX_WIDTH) begin : g_lo
      assign new_low[i*PW +: PW] = lane_pix[i];
    end else begin : g_lo_zero
      assign new_low[i*PW +: PW] = '0;
    end
    if (i + HB < MAX_WIDTH) begin : g_hi
      assign new_high[i*PW +: PW] = lane_pix[i + HB];
    end else begin : g_hi_zero
      assign new_high[i*PW +: PW] = '0;
    end
  end

  assign pop                     = pred_row.valid && pred_row.ready;
  assign space                   = (count != 2'd2);
  assign pred_row.valid          = (count != 2'd0);
  assign pred_row.pred_pixels_low  = slot0_low;
  assign pred_row.pred_pixels_high = slot0_high;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Buffer payload
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        slot0_low  <= new_low;
        slot0_high <= new_high;
      end else begin
        slot0_low  <= slot1_low;
        slot0_high <= slot1_high;
        slot1_low  <= new_low;
        slot1_high <= new_high;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0_low  <= new_low;
        slot0_high <= new_high;
      end else begin
        slot1_low  <= new_low;
        slot1_high <= new_high;
      end
    end else if (pop) begin
      slot0_low  <= slot1_low;
      slot0_high <= slot1_high;
    end
  end

`ifndef SYNTHESIS
  // No write into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2))
    else $error("hpmc_merge: push into full buffer");

  // Buffer is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (count == 2'd0))
    else $error("hpmc_merge: buffer not empty after reset");

  // A lone push into one waiting entry fills the buffer
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1 && push && !pop) |=> (count == 2'd2))
    else $error("hpmc_merge: occupancy lost on push");

  // Occupancy never exceeds two entries
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("hpmc_merge: occupancy out of range");
`endif

endmodule

/* hdl/half_pel_motion_compensation.sv */
// A result is registered in the output buffer when its row is accepted.
// Throughput: one row per cycle while the output buffer has space; all pixels go through parallel lanes at once.
// A two-entry output buffer keeps accepting while one result waits downstream.
// Priming rows (block start with vertical half-pel) give no result.
// Reset (rst, synchronous) empties the buffer and zeroes the previous-row store.
// ----------------------------------------------------------------------------
// half_pel_motion_compensation
// Half-pel prediction of one 8- or MAX_WIDTH-pixel row per transfer.
// ----------------------------------------------------------------------------
module half_pel_motion_compensation #(
  parameter int MAX_WIDTH = hpmc_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hpmc_in_if.sink     ref_row,
  hpmc_out_if.source  pred_row
);

  localparam int PW  = hpmc_pkg::PIX_W;
  localparam int HB  = hpmc_pkg::HALF_BYTES;
  localparam int NW  = hpmc_pkg::NARROW_WIDTH;
  localparam int LEN = MAX_WIDTH + 1;

  logic [PW-1:0]   previous_row [LEN];
  logic [PW-1:0]   cur_row      [LEN];
  logic [PW-1:0]   lane_pix     [MAX_WIDTH];
  logic            in_xfer;
  logic            push;
  logic            space;
  hpmc_pkg::mode_t mode;

  assign ref_row.ready = space;
  assign in_xfer       = ref_row.valid && ref_row.ready;
  assign push          = in_xfer && !(ref_row.half_y && ref_row.block_start);

  assign mode.half_x       = ref_row.half_x;
  assign mode.half_y       = ref_row.half_y;
  assign mode.average_mode = ref_row.average_mode;

  // Current row: used pixels, then the extra pixel, then zeros
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_row
    if (i < HB) begin : g_low
      assign cur_row[i] = ref_row.ref_pixels_low[i*PW +: PW];
    end else if (i == NW) begin : g_first_high
      assign cur_row[i] = ref_row.wide_block ?
                          ref_row.ref_pixels_high[(i-HB)*PW +: PW] :
                          ref_row.ref_pixel_extra;
    end else begin : g_high
      assign cur_row[i] = ref_row.wide_block ?
                          ref_row.ref_pixels_high[(i-HB)*PW +: PW] : '0;
    end
  end

  if (MAX_WIDTH == NW) begin : g_tail_narrow
    assign cur_row[MAX_WIDTH] = ref_row.ref_pixel_extra;
  end else begin : g_tail_wide
    assign cur_row[MAX_WIDTH] = ref_row.wide_block ? ref_row.ref_pixel_extra : '0;
  end

  // Previous-row store, rewritten by every accepted row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEN; k++) begin
        previous_row[k] <= '0;
      end
    end else if (in_xfer) begin
      for (int k = 0; k < LEN; k++) begin
        previous_row[k] <= cur_row[k];
      end
    end
  end

  // One lane per pixel
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_lane
    logic [PW-1:0] dest;
    logic          en;

    if (i < HB) begin : g_dl
      assign dest = ref_row.dest_pixels_low[i*PW +: PW];
      assign en   = 1'b1;
    end else begin : g_dh
      assign dest = ref_row.dest_pixels_high[(i-HB)*PW +: PW];
      assign en   = ref_row.wide_block;
    end

    hpmc_lane u_lane (
      .a    (cur_row[i]),
      .b    (cur_row[i+1]),
      .c    (previous_row[i]),
      .d    (previous_row[i+1]),
      .dest (dest),
      .mode (mode),
      .en   (en),
      .pix  (lane_pix[i])
    );
  end

  // Pack and buffer results
  hpmc_merge #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .lane_pix (lane_pix),
    .push     (push),
    .space    (space),
    .pred_row (pred_row)
  );

endmodule

/* dv/half_pel_motion_compensation_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_pel_motion_compensation_test
// Self-checking bench for the half-pel prediction block. Rows go in through a
// bursty valid/ready sender and come out to a receiver that stalls on its own
// schedule. A behavioral predictor with its own copy of the previous-row store
// works out each prediction, which is then compared with the block's output.
// ----------------------------------------------------------------------------
module half_pel_motion_compensation_test;

  localparam int PIX_W         = hpmc_pkg::PIX_W;
  localparam int HALF_W        = hpmc_pkg::HALF_W;
  localparam int HALF_BYTES    = hpmc_pkg::HALF_BYTES;
  localparam int NARROW_WIDTH  = hpmc_pkg::NARROW_WIDTH;
  localparam int ROW_W         = hpmc_pkg::MAX_WIDTH_DEF;
  localparam int DRAIN_SPACING = 400;
  localparam logic [PIX_W-1:0] CORNER_PIX [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

  typedef hpmc_pkg::mode_t mode_t;

  typedef struct packed {
    logic [HALF_W-1:0] ref_low;
    logic [HALF_W-1:0] ref_high;
    logic [PIX_W-1:0]  ref_extra;
    logic [HALF_W-1:0] dest_low;
    logic [HALF_W-1:0] dest_high;
    mode_t             mode;
    logic              wide_block;
    logic              block_start;
  } row_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] low;
    logic [HALF_W-1:0] high;
  } pred_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SLOW} rx_style_t;

  logic clk = 1'b0;
  logic rst;

  hpmc_in_if  ref_row ();
  hpmc_out_if pred_row ();

  half_pel_motion_compensation uut (
    .clk      (clk),
    .rst      (rst),
    .ref_row  (ref_row),
    .pred_row (pred_row)
  );

  always #4 clk = ~clk;

  // Predictor state and scoreboard
  logic [PIX_W-1:0] prev_row [0:ROW_W];
  pred_t            expected_preds [$];
  int               rows_sent     = 0;
  int               priming_rows  = 0;
  int               preds_checked = 0;
  int               mismatches    = 0;
  int               missing_preds = 0;

  // Sender pacing
  bit idle_enable = 1'b1;
  int burst_left  = 0;

  // Receiver pacing
  rx_style_t rx_style      = RX_OPEN;
  int        rx_phase_left = 0;

  // Prediction of one row; returns 0 for a priming row
  function automatic bit predict_row(input row_item_t r, output pred_t p);
    logic [PIX_W-1:0] cur [0:ROW_W];
    int               w;
    int unsigned      a, b, c, d, v, dst;
    w = r.wide_block ? ROW_W : NARROW_WIDTH;
    p = '0;
    for (int i = 0; i <= ROW_W; i++) cur[i] = '0;
    for (int i = 0; i < w; i++)
      cur[i] = (i < HALF_BYTES) ? r.ref_low[PIX_W*i +: PIX_W]
                                : r.ref_high[PIX_W*(i-HALF_BYTES) +: PIX_W];
    cur[w] = r.ref_extra;
    if (r.mode.half_y && r.block_start) begin
      prev_row = cur;
      return 1'b0;
    end
    for (int i = 0; i < w; i++) begin
      a = cur[i];
      b = cur[i+1];
      c = prev_row[i];
      d = prev_row[i+1];
      if (r.mode.half_x && r.mode.half_y) v = (a + b + c + d + 2) >> 2;
      else if (r.mode.half_x)             v = (a + b + 1) >> 1;
      else if (r.mode.half_y)             v = (a + c + 1) >> 1;
      else                                v = a;
      if (r.mode.average_mode) begin
        dst = (i < HALF_BYTES) ? r.dest_low[PIX_W*i +: PIX_W]
                               : r.dest_high[PIX_W*(i-HALF_BYTES) +: PIX_W];
        v = (v + dst + 1) >> 1;
      end
      if (i < HALF_BYTES) p.low[PIX_W*i +: PIX_W] = 8'(v);
      else                p.high[PIX_W*(i-HALF_BYTES) +: PIX_W] = 8'(v);
    end
    prev_row = cur;
    return 1'b1;
  endfunction

  // Eight pixels: mostly random, sometimes flat, near-flat or corner values
  function automatic logic [HALF_W-1:0] random_pixels();
    logic [HALF_W-1:0] v;
    int                base;
    v = '0;
    case ($urandom_range(0, 9))
      0: v = '1;
      1: v = '0;
      2: begin
        base = $urandom_range(0, 255);
        for (int i = 0; i < HALF_BYTES; i++)
          v[PIX_W*i +: PIX_W] = 8'(base ^ $urandom_range(0, 3));
      end
      3: for (int i = 0; i < HALF_BYTES; i++)
           v[PIX_W*i +: PIX_W] = CORNER_PIX[$urandom_range(0, 5)];
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic row_item_t make_row(input logic hx, hy, avg, wide, first);
    row_item_t r;
    r.ref_low           = random_pixels();
    r.ref_high          = random_pixels();
    r.ref_extra         = ($urandom_range(0, 3) == 0) ? CORNER_PIX[$urandom_range(0, 5)]
                                                      : 8'($urandom_range(0, 255));
    r.dest_low          = random_pixels();
    r.dest_high         = random_pixels();
    r.mode.half_x       = hx;
    r.mode.half_y       = hy;
    r.mode.average_mode = avg;
    r.wide_block        = wide;
    r.block_start       = first;
    return r;
  endfunction

  // One row transfer, with a random gap at the start of each burst when idling is enabled
  task automatic send_row(input row_item_t r);
    pred_t p;
    int    gap;
    if (idle_enable && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      ref_row.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    ref_row.ref_pixels_low   <= r.ref_low;
    ref_row.ref_pixels_high  <= r.ref_high;
    ref_row.ref_pixel_extra  <= r.ref_extra;
    ref_row.dest_pixels_low  <= r.dest_low;
    ref_row.dest_pixels_high <= r.dest_high;
    ref_row.half_x           <= r.mode.half_x;
    ref_row.half_y           <= r.mode.half_y;
    ref_row.average_mode     <= r.mode.average_mode;
    ref_row.wide_block       <= r.wide_block;
    ref_row.block_start      <= r.block_start;
    ref_row.valid            <= 1'b1;
    do @(posedge clk); while (!ref_row.ready);
    rows_sent++;
    if (predict_row(r, p)) expected_preds.push_back(p);
    else priming_rows++;
  endtask

  // Hold the sender until every expected prediction has come out
  task automatic wait_drained();
    ref_row.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_preds.size() != 0);
  endtask

  // Vertical modes straight after reset, against the cleared store
  task automatic test_unprimed_vertical();
    send_row(make_row(1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_row(make_row(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
  endtask

  // Saturated and rounding-sensitive pixel values
  task automatic test_pixel_extremes();
    row_item_t r;
    r = make_row(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    r.ref_low = '1; r.ref_high = '1; r.ref_extra = '1;
    send_row(r);
    r = make_row(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    r.ref_low = '0; r.ref_high = '0; r.dest_low = '1; r.dest_high = '1;
    send_row(r);
    r = make_row(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    r.ref_low = '1; r.ref_high = '1; r.ref_extra = '1; r.dest_low = '0; r.dest_high = '0;
    send_row(r);
    r = make_row(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    r.ref_low = {4{16'hFF00}}; r.ref_extra = 8'hFF; r.dest_low = {8{8'hFE}};
    send_row(r);
  endtask

  // Every interpolation mode, put on wide rows and average on narrow rows
  task automatic test_interpolation_modes();
    logic hx, hy;
    for (int m = 0; m < 4; m++) begin
      hx = m[0];
      hy = m[1];
      if (hy) send_row(make_row(hx, hy, 1'b0, 1'b1, 1'b1));
      send_row(make_row(hx, hy, 1'b0, 1'b1, 1'b0));
      send_row(make_row(hx, hy, 1'b1, 1'b0, 1'b0));
    end
  endtask

  // Start flag without vertical mode, priming, and width changes in a block
  task automatic test_priming_and_width_change();
    send_row(make_row(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_row(make_row(1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
    send_row(make_row(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
    send_row(make_row(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_row(make_row(1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
  endtask

  // Well-formed blocks with random content, plus noise and broken blocks
  task automatic test_random_blocks(input int count);
    row_item_t r;
    int        n, height, next_drain;
    logic      hx, hy, avg, wide;
    n          = 0;
    next_drain = DRAIN_SPACING;
    while (n < count) begin
      if (n >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_SPACING;
      end
      if ($urandom_range(0, 99) < 8) begin
        send_row(make_row(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom)));
        n++;
        continue;
      end
      hx          = 1'($urandom);
      hy          = 1'($urandom);
      avg         = 1'($urandom);
      wide        = ($urandom_range(0, 3) != 0);
      height      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 17) : $urandom_range(1, 8);
      idle_enable = ($urandom_range(0, 4) != 0);
      for (int row = 0; row < height + hy; row++) begin
        r = make_row(hx, hy, avg, wide, row == 0);
        // occasional width flip or misplaced start inside a block
        if ($urandom_range(0, 49) == 0) r.wide_block  = ~r.wide_block;
        if ($urandom_range(0, 49) == 0) r.block_start = ~r.block_start;
        send_row(r);
        n++;
      end
    end
    idle_enable = 1'b1;
  endtask

  // Receiver ready, switching between open, random and mostly stalled
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_style      <= rx_style_t'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(16, 300);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_style)
      RX_OPEN:   pred_row.ready <= 1'b1;
      RX_RANDOM: pred_row.ready <= 1'($urandom);
      default:   pred_row.ready <= ($urandom_range(0, 6) == 0);
    endcase
  end

  // Compare each output transfer with the oldest expected prediction
  always @(posedge clk) begin : check_prediction
    pred_t want;
    if (!rst && pred_row.valid && pred_row.ready) begin
      if (expected_preds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected prediction %h_%h", $realtime,
                   pred_row.pred_pixels_high, pred_row.pred_pixels_low);
      end else begin
        want = expected_preds.pop_front();
        preds_checked++;
        if (pred_row.pred_pixels_low !== want.low) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pred_pixels_low expected %h got %h", $realtime,
                     want.low, pred_row.pred_pixels_low);
        end
        if (pred_row.pred_pixels_high !== want.high) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pred_pixels_high expected %h got %h", $realtime,
                     want.high, pred_row.pred_pixels_high);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d predictions outstanding", expected_preds.size());
    $display("half_pel_motion_compensation test failed");
    $finish;
  end

  initial begin
    for (int i = 0; i <= ROW_W; i++) prev_row[i] = '0;
    rst                      <= 1'b1;
    ref_row.valid            <= 1'b0;
    ref_row.ref_pixels_low   <= '0;
    ref_row.ref_pixels_high  <= '0;
    ref_row.ref_pixel_extra  <= '0;
    ref_row.dest_pixels_low  <= '0;
    ref_row.dest_pixels_high <= '0;
    ref_row.half_x           <= 1'b0;
    ref_row.half_y           <= 1'b0;
    ref_row.average_mode     <= 1'b0;
    ref_row.wide_block       <= 1'b0;
    ref_row.block_start      <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_unprimed_vertical();
    test_pixel_extremes();
    test_interpolation_modes();
    test_priming_and_width_change();
    wait_drained();
    test_random_blocks(1880);

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_preds.size() != 0) begin
      missing_preds = expected_preds.size();
      $display("%0d predictions never arrived", missing_preds);
    end
    $display("sent %0d rows in all modes and widths, %0d of them priming rows",
             rows_sent, priming_rows);
    $display("checked %0d predictions, %0d mismatches", preds_checked, mismatches);
    if (mismatches == 0 && missing_preds == 0) begin
      $display("half_pel_motion_compensation test passed");
    end else begin
      $display("half_pel_motion_compensation test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/hpmc_pkg.sv
hdl/hpmc_if.sv
hdl/hpmc_lane.sv
hdl/hpmc_merge.sv
hdl/half_pel_motion_compensation.sv
dv/half_pel_motion_compensation_test.sv
